FILE: design/qtlm_pkg.sv
// Package for the quadrotor thrust limiting mixer.
// Holds the fixed widths, thrust constants, register indexes and reset values.
// Used by qtlm_div and quadrotor_thrust_limit_mixer; depends on nothing.
`default_nettype none
package qtlm_pkg;

	localparam int VALUE_WIDTH_DEF = 16;
	localparam int THRUST_WIDTH    = 15;
	localparam int TERM_WIDTH      = 15;
	localparam int MOTOR_WIDTH     = 15;
	localparam int FLOOR_WIDTH     = 14;
	localparam int WEIGHT_WIDTH    = 8;
	localparam int ALLOC_WIDTH     = 14;
	localparam int QUO_WIDTH       = 14;
	localparam int CFG_INDEX_WIDTH = 2;
	localparam int CFG_DATA_WIDTH  = 14;

	localparam int FULL_THRUST = 25600;

	localparam logic [FLOOR_WIDTH-1:0]  FLOOR_RESET   = 14'd3840;
	localparam logic [WEIGHT_WIDTH-1:0] ROLL_W_RESET  = 8'd51;
	localparam logic [WEIGHT_WIDTH-1:0] PITCH_W_RESET = 8'd102;
	localparam logic [WEIGHT_WIDTH-1:0] YAW_W_RESET   = 8'd102;

	typedef enum logic [CFG_INDEX_WIDTH-1:0] {
		REG_FLOOR   = 2'd0,
		REG_ROLL_W  = 2'd1,
		REG_PITCH_W = 2'd2,
		REG_YAW_W   = 2'd3
	} reg_index_t;

endpackage
`default_nettype wire

FILE: design/quadrotor_thrust_limit_mixer.sv
// Top level of the quadrotor thrust limiting motor mixer.
// Depends on qtlm_pkg and instantiates three qtlm_div dividers.
`default_nettype none
// The mixer takes one transaction in every clock cycle: busy is always low, and
// each result appears with done. The pipeline is four arithmetic stages, the
// 14-stage pipelined divider that rescales the attitude terms, and one output
// stage. Results are shown for a single cycle and cannot be held off by the
// receiver. Configuration registers take effect on the next cycle.
module quadrotor_thrust_limit_mixer #(
	parameter int VALUE_WIDTH = qtlm_pkg::VALUE_WIDTH_DEF
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   start,
	output logic                                        busy,
	input  wire logic [qtlm_pkg::THRUST_WIDTH-1:0]      hover_thrust,
	input  wire logic signed [VALUE_WIDTH-1:0]          vertical_request,
	input  wire logic signed [VALUE_WIDTH-1:0]          roll_request,
	input  wire logic signed [VALUE_WIDTH-1:0]          pitch_request,
	input  wire logic signed [VALUE_WIDTH-1:0]          yaw_request,
	output logic                                        done,
	output logic signed [VALUE_WIDTH-1:0]               vertical_limited,
	output logic signed [qtlm_pkg::TERM_WIDTH-1:0]      roll_limited,
	output logic signed [qtlm_pkg::TERM_WIDTH-1:0]      pitch_limited,
	output logic signed [qtlm_pkg::TERM_WIDTH-1:0]      yaw_limited,
	output logic [qtlm_pkg::MOTOR_WIDTH-1:0]            motor_one,
	output logic [qtlm_pkg::MOTOR_WIDTH-1:0]            motor_two,
	output logic [qtlm_pkg::MOTOR_WIDTH-1:0]            motor_three,
	output logic [qtlm_pkg::MOTOR_WIDTH-1:0]            motor_four,
	input  wire logic                                   cfg_write,
	input  wire logic [qtlm_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
	input  wire logic [qtlm_pkg::CFG_DATA_WIDTH-1:0]    cfg_data
);

	localparam int VW  = VALUE_WIDTH;
	localparam int HW  = qtlm_pkg::THRUST_WIDTH;
	localparam int AW  = qtlm_pkg::ALLOC_WIDTH;
	localparam int QW  = qtlm_pkg::QUO_WIDTH;
	localparam int BW  = (VW > HW) ? VW : HW;
	localparam int SW  = BW + 2;
	localparam int ZW  = BW + 3;
	localparam int RW  = VW + 2;
	localparam int WW  = VW + qtlm_pkg::WEIGHT_WIDTH;
	localparam int SMW = WW + 2;
	localparam int PW  = AW + WW;
	localparam int NW  = PW + 2;
	localparam int TW  = BW + 1;
	localparam int MTW = ZW + 3;
	localparam int LAT = QW + 5;

	localparam logic signed [ZW-1:0]  FULL_Z = ZW'(qtlm_pkg::FULL_THRUST);
	localparam logic signed [MTW-1:0] FULL_M = MTW'(qtlm_pkg::FULL_THRUST);

	typedef struct packed {
		logic [HW-1:0]        h;
		logic signed [ZW-1:0] z;
		logic signed [VW-1:0] a;
		logic signed [VW-1:0] b;
		logic signed [VW-1:0] g;
		logic                 resc;
		logic                 szero;
	} carry_t;

	logic [qtlm_pkg::FLOOR_WIDTH-1:0]  floor_q;
	logic [qtlm_pkg::WEIGHT_WIDTH-1:0] roll_w_q;
	logic [qtlm_pkg::WEIGHT_WIDTH-1:0] pitch_w_q;
	logic [qtlm_pkg::WEIGHT_WIDTH-1:0] yaw_w_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			floor_q   <= qtlm_pkg::FLOOR_RESET;
			roll_w_q  <= qtlm_pkg::ROLL_W_RESET;
			pitch_w_q <= qtlm_pkg::PITCH_W_RESET;
			yaw_w_q   <= qtlm_pkg::YAW_W_RESET;
		end else if (cfg_write) begin
			unique case (qtlm_pkg::reg_index_t'(cfg_index))
				qtlm_pkg::REG_FLOOR:   floor_q   <= cfg_data;
				qtlm_pkg::REG_ROLL_W:  roll_w_q  <= cfg_data[qtlm_pkg::WEIGHT_WIDTH-1:0];
				qtlm_pkg::REG_PITCH_W: pitch_w_q <= cfg_data[qtlm_pkg::WEIGHT_WIDTH-1:0];
				qtlm_pkg::REG_YAW_W:   yaw_w_q   <= cfg_data[qtlm_pkg::WEIGHT_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	// Stage 1: magnitudes and the hover plus vertical sum.
	logic v_s1;
	logic [HW-1:0]        h_s1;
	logic signed [VW-1:0] zr_s1, ar_s1, br_s1, gr_s1;
	logic [VW-1:0]        ma_s1, mb_s1, mg_s1;
	logic signed [SW-1:0] s_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else v_s1 <= start && !busy;
	end

	always_ff @(posedge clk) begin
		h_s1  <= hover_thrust;
		zr_s1 <= vertical_request;
		ar_s1 <= roll_request;
		br_s1 <= pitch_request;
		gr_s1 <= yaw_request;
		ma_s1 <= roll_request[VW-1] ? (~roll_request + 1'b1) : roll_request;
		mb_s1 <= pitch_request[VW-1] ? (~pitch_request + 1'b1) : pitch_request;
		mg_s1 <= yaw_request[VW-1] ? (~yaw_request + 1'b1) : yaw_request;
		s_s1  <= $signed({{(SW-HW){1'b0}}, hover_thrust})
			+ $signed({{(SW-VW){vertical_request[VW-1]}}, vertical_request});
	end

	// Stage 2: attitude allowance and weighted magnitudes.
	logic signed [ZW-1:0] s_ext, up_c, el_c, fl_c, mx_c;
	logic [RW-1:0]        req_c;
	logic [AW-1:0]        alloc_c;

	always_comb begin
		s_ext   = $signed({{(ZW-SW){s_s1[SW-1]}}, s_s1});
		up_c    = FULL_Z - s_ext;
		el_c    = (up_c < s_ext) ? up_c : s_ext;
		fl_c    = $signed({{(ZW-qtlm_pkg::FLOOR_WIDTH){1'b0}}, floor_q});
		mx_c    = (el_c < fl_c) ? fl_c : el_c;
		req_c   = RW'(ma_s1) + RW'(mb_s1) + RW'(mg_s1);
		alloc_c = (req_c < RW'(mx_c[AW-1:0])) ? req_c[AW-1:0] : mx_c[AW-1:0];
	end

	logic v_s2;
	logic [HW-1:0]        h_s2;
	logic signed [VW-1:0] zr_s2, ar_s2, br_s2, gr_s2;
	logic [RW-1:0]        req_s2;
	logic [AW-1:0]        alloc_s2;
	logic [WW-1:0]        wa_s2, wb_s2, wg_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		h_s2     <= h_s1;
		zr_s2    <= zr_s1;
		ar_s2    <= ar_s1;
		br_s2    <= br_s1;
		gr_s2    <= gr_s1;
		req_s2   <= req_c;
		alloc_s2 <= alloc_c;
		wa_s2    <= WW'(roll_w_q) * WW'(ma_s1);
		wb_s2    <= WW'(pitch_w_q) * WW'(mb_s1);
		wg_s2    <= WW'(yaw_w_q) * WW'(mg_s1);
	end

	// Stage 3: vertical clamp, weighted sum and allowance products.
	logic signed [ZW-1:0] h_z, al_z, zr_z, lo_c, hi_c, zt_c, z_c;
	logic [SMW-1:0]       sum_c;

	always_comb begin
		h_z   = $signed({{(ZW-HW){1'b0}}, h_s2});
		al_z  = $signed({{(ZW-AW){1'b0}}, alloc_s2});
		zr_z  = $signed({{(ZW-VW){zr_s2[VW-1]}}, zr_s2});
		lo_c  = al_z - h_z;
		hi_c  = FULL_Z - h_z - al_z;
		zt_c  = (zr_z < lo_c) ? lo_c : zr_z;
		z_c   = (zt_c > hi_c) ? hi_c : zt_c;
		sum_c = SMW'(wa_s2) + SMW'(wb_s2) + SMW'(wg_s2);
	end

	logic v_s3;
	carry_t        c_s3;
	logic [SMW-1:0] sum_s3;
	logic [PW-1:0]  pa_s3, pb_s3, pg_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		c_s3.h     <= h_s2;
		c_s3.z     <= z_c;
		c_s3.a     <= ar_s2;
		c_s3.b     <= br_s2;
		c_s3.g     <= gr_s2;
		c_s3.resc  <= (req_s2 > RW'(alloc_s2));
		c_s3.szero <= (sum_c == '0);
		sum_s3     <= sum_c;
		pa_s3      <= PW'(alloc_s2) * PW'(wa_s2);
		pb_s3      <= PW'(alloc_s2) * PW'(wb_s2);
		pg_s3      <= PW'(alloc_s2) * PW'(wg_s2);
	end

	// Stage 4: divider operands for round-to-nearest shares.
	logic v_s4;
	carry_t        c_s4;
	logic [NW-1:0] na_s4, nb_s4, ng_s4, d_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		c_s4  <= c_s3;
		na_s4 <= {pa_s3, 1'b0} + NW'(sum_s3);
		nb_s4 <= {pb_s3, 1'b0} + NW'(sum_s3);
		ng_s4 <= {pg_s3, 1'b0} + NW'(sum_s3);
		d_s4  <= NW'({sum_s3, 1'b0});
	end

	logic [QW-1:0] qa, qb, qg;

	qtlm_div #(.NUM_W(NW), .QUO_W(QW)) u_div_roll (
		.clk(clk), .num(na_s4), .den(d_s4), .quo(qa)
	);
	qtlm_div #(.NUM_W(NW), .QUO_W(QW)) u_div_pitch (
		.clk(clk), .num(nb_s4), .den(d_s4), .quo(qb)
	);
	qtlm_div #(.NUM_W(NW), .QUO_W(QW)) u_div_yaw (
		.clk(clk), .num(ng_s4), .den(d_s4), .quo(qg)
	);

	logic   vd_s [QW];
	carry_t cd_s [QW];

	for (genvar k = 0; k < QW; k++) begin : g_delay
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vd_s[k] <= 1'b0;
			else vd_s[k] <= (k == 0) ? v_s4 : vd_s[(k == 0) ? 0 : k-1];
		end
		always_ff @(posedge clk) begin
			cd_s[k] <= (k == 0) ? c_s4 : cd_s[(k == 0) ? 0 : k-1];
		end
	end

	// Output stage: term selection, mixing matrix and saturation.
	function automatic logic signed [TW-1:0] pick(input logic signed [VW-1:0] raw,
		input logic [QW-1:0] q, input logic resc, input logic szero);
		logic signed [TW-1:0] qm;
		qm = $signed({{(TW-QW){1'b0}}, q});
		if (!resc) return $signed({{(TW-VW){raw[VW-1]}}, raw});
		else if (szero) return '0;
		else if (raw[VW-1]) return -qm;
		else return qm;
	endfunction

	function automatic logic [qtlm_pkg::MOTOR_WIDTH-1:0] sat(input logic signed [MTW-1:0] x);
		if (x < 0) return '0;
		else if (x > FULL_M) return qtlm_pkg::MOTOR_WIDTH'(qtlm_pkg::FULL_THRUST);
		else return x[qtlm_pkg::MOTOR_WIDTH-1:0];
	endfunction

	carry_t               cf;
	logic signed [TW-1:0]  ta, tb, tg;
	logic signed [MTW-1:0] base_c, ea, eb, eg;

	always_comb begin
		cf     = cd_s[QW-1];
		ta     = pick(cf.a, qa, cf.resc, cf.szero);
		tb     = pick(cf.b, qb, cf.resc, cf.szero);
		tg     = pick(cf.g, qg, cf.resc, cf.szero);
		base_c = $signed({{(MTW-HW){1'b0}}, cf.h}) + $signed({{(MTW-ZW){cf.z[ZW-1]}}, cf.z});
		ea     = $signed({{(MTW-TW){ta[TW-1]}}, ta});
		eb     = $signed({{(MTW-TW){tb[TW-1]}}, tb});
		eg     = $signed({{(MTW-TW){tg[TW-1]}}, tg});
	end

	logic v_s5;
	logic signed [VW-1:0]                     z_s5;
	logic signed [qtlm_pkg::TERM_WIDTH-1:0]   a_s5, b_s5, g_s5;
	logic [qtlm_pkg::MOTOR_WIDTH-1:0]         m1_s5, m2_s5, m3_s5, m4_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else v_s5 <= vd_s[QW-1];
	end

	always_ff @(posedge clk) begin
		z_s5  <= cf.z[VW-1:0];
		a_s5  <= ta[qtlm_pkg::TERM_WIDTH-1:0];
		b_s5  <= tb[qtlm_pkg::TERM_WIDTH-1:0];
		g_s5  <= tg[qtlm_pkg::TERM_WIDTH-1:0];
		m1_s5 <= sat(base_c - ea + eb - eg);
		m2_s5 <= sat(base_c + ea + eb + eg);
		m3_s5 <= sat(base_c - ea - eb + eg);
		m4_s5 <= sat(base_c + ea - eb - eg);
	end

	assign done             = v_s5;
	assign vertical_limited = z_s5;
	assign roll_limited     = a_s5;
	assign pitch_limited    = b_s5;
	assign yaw_limited      = g_s5;
	assign motor_one        = m1_s5;
	assign motor_two        = m2_s5;
	assign motor_three      = m3_s5;
	assign motor_four       = m4_s5;

`ifndef SYNTHESIS
	// Every transaction produces its result after the fixed latency.
	a_latency_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LAT done)
		else $error("accepted transaction produced no result");

	a_latency_bwd: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result without a matching transaction");

	a_motor_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (motor_one <= 15'd25600 && motor_two <= 15'd25600
			&& motor_three <= 15'd25600 && motor_four <= 15'd25600))
		else $error("motor command above full thrust");
`endif

endmodule
`default_nettype wire

FILE: design/qtlm_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
// The quotient must fit QUO_W bits; uses qtlm_pkg for the default width.
`default_nettype none
module qtlm_div #(
	parameter int NUM_W = 40,
	parameter int QUO_W = qtlm_pkg::QUO_WIDTH
) (
	input  wire logic             clk,
	input  wire logic [NUM_W-1:0] num,
	input  wire logic [NUM_W-1:0] den,
	output logic      [QUO_W-1:0] quo
);

	logic [NUM_W-1:0] rem_s [QUO_W-1];
	logic [NUM_W-1:0] den_s [QUO_W-1];
	logic [QUO_W-1:0] quo_s [QUO_W];

	for (genvar k = 0; k < QUO_W; k++) begin : g_stage
		logic [NUM_W-1:0] r_in;
		logic [NUM_W-1:0] d_in;
		logic [QUO_W-1:0] q_in;
		logic [NUM_W-1:0] d_sh;
		logic             ge;

		if (k == 0) begin : g_first
			assign r_in = num;
			assign d_in = den;
			assign q_in = '0;
		end else begin : g_next
			assign r_in = rem_s[k-1];
			assign d_in = den_s[k-1];
			assign q_in = quo_s[k-1];
		end

		assign d_sh = d_in << (QUO_W - 1 - k);
		assign ge   = (r_in >= d_sh);

		always_ff @(posedge clk) begin
			quo_s[k] <= {q_in[QUO_W-2:0], ge};
		end

		if (k < QUO_W - 1) begin : g_carry
			always_ff @(posedge clk) begin
				rem_s[k] <= ge ? (r_in - d_sh) : r_in;
				den_s[k] <= d_in;
			end
		end
	end

	assign quo = quo_s[QUO_W-1];

endmodule
`default_nettype wire
